/* src/rerc_pkg.sv */
// ----------------------------------------------------------------------------
// rerc_pkg
// Shared widths, register indexes, reset values and types of the rail end
// reversal controller.
// ----------------------------------------------------------------------------
package rerc_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int COUNT_WIDTH    = 16;

  // fixed field widths
  localparam int DIST_W  = 24;
  localparam int BASE_W  = 13;
  localparam int GAIN_W  = 12;
  localparam int LIM_W   = 16;
  localparam int MSPD_W  = 16;
  localparam int TSPD_W  = 18;
  localparam int DEP_W   = 14;
  localparam int GAIN_FRAC = 8;
  localparam int PROD_W  = BASE_W + GAIN_W;

  // configuration port
  localparam int CFG_DATA_W = (POSITION_WIDTH > DIST_W) ? POSITION_WIDTH : DIST_W;
  localparam int CFG_IDX_W  = 3;

  // exact position sums and count compares
  localparam int SUM_W = ((POSITION_WIDTH > DIST_W) ? POSITION_WIDTH : DIST_W) + 2;
  localparam int CMP_W = (COUNT_WIDTH > LIM_W) ? COUNT_WIDTH : LIM_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_ZONE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 3'd7;

  // register reset values
  localparam logic [DIST_W-1:0] RST_STOP_ZONE     = 24'd8000;
  localparam logic [BASE_W-1:0] RST_BASE_SPEED    = 13'd4000;
  localparam logic [GAIN_W-1:0] RST_POWER_GAIN    = 12'd256;
  localparam logic [LIM_W-1:0]  RST_STUCK_LIMIT   = 16'd3000;
  localparam logic [LIM_W-1:0]  RST_RELEASE_DELAY = 16'd2000;

  typedef struct packed {
    logic [POSITION_WIDTH-1:0] right_limit;
    logic [POSITION_WIDTH-1:0] left_limit;
    logic [DIST_W-1:0]         reverse_margin;
    logic [DIST_W-1:0]         stop_zone;
    logic [BASE_W-1:0]         base_speed;
    logic [GAIN_W-1:0]         power_gain;
    logic [LIM_W-1:0]          stuck_limit;
    logic [LIM_W-1:0]          release_delay;
  } cfg_t;

  typedef struct packed {
    logic [TSPD_W-1:0] target_speed;
    logic              end_stop;
  } result_t;

endpackage

/* src/rerc_if.sv */
// ----------------------------------------------------------------------------
// rerc_in_if / rerc_out_if
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface rerc_in_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [rerc_pkg::POSITION_WIDTH-1:0] encoder_position;
  logic signed [rerc_pkg::MSPD_W-1:0]         motor_speed;

  modport source (output valid, output encoder_position, output motor_speed, input ready);
  modport sink   (input valid, input encoder_position, input motor_speed, output ready);
endinterface

interface rerc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rerc_pkg::TSPD_W-1:0] target_speed;
  logic                                end_stop;

  modport source (output valid, output target_speed, output end_stop, input ready);
  modport sink   (input valid, input target_speed, input end_stop, output ready);
endinterface

/* src/rail_end_reversal_controller_top.sv */
// ----------------------------------------------------------------------------
// rail_end_reversal_controller_top
// Path: an item passes the input register, then the result register;
// either register can hold it while the output stalls.
// Throughput: one item per cycle while out_ch.ready is high; the input
// register lets a new item enter while a finished result still waits.
// Reset: synchronous, empties both registers, clears the tick state and loads
// the register defaults.
// ----------------------------------------------------------------------------
module rail_end_reversal_controller_top (
  input  logic                            clk,
  input  logic                            rst,
  rerc_in_if.sink                         in_ch,
  rerc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rerc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rerc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rerc_pkg::*;

  cfg_t                      cfg;
  result_t                   result;
  logic                      s1_valid;
  logic [POSITION_WIDTH-1:0] s1_pos;
  logic [MSPD_W-1:0]         s1_speed;
  logic                      s1_adv;
  logic                      out_valid;

  rerc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rerc_core u_core (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .fire             (s1_adv),
    .encoder_position (s1_pos),
    .motor_speed      (s1_speed),
    .result           (result)
  );

  // handshake
  assign s1_adv      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_pos   <= in_ch.encoder_position;
      s1_speed <= in_ch.motor_speed;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch.target_speed <= result.target_speed;
      out_ch.end_stop     <= result.end_stop;
    end
  end

  assign out_ch.valid = out_valid;

  // checks
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input transfer while both stages are stalled");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced item missing from result register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("stages not empty after reset");

endmodule

/* src/rerc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rerc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rerc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rerc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rerc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rerc_pkg::cfg_t                 cfg
);
  import rerc_pkg::*;

  // decode and load one register per write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right_limit    <= '0;
      cfg.left_limit     <= '0;
      cfg.reverse_margin <= '0;
      cfg.stop_zone      <= RST_STOP_ZONE;
      cfg.base_speed     <= RST_BASE_SPEED;
      cfg.power_gain     <= RST_POWER_GAIN;
      cfg.stuck_limit    <= RST_STUCK_LIMIT;
      cfg.release_delay  <= RST_RELEASE_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RIGHT_LIMIT:    cfg.right_limit    <= cfg_wdata[POSITION_WIDTH-1:0];
        REG_LEFT_LIMIT:     cfg.left_limit     <= cfg_wdata[POSITION_WIDTH-1:0];
        REG_REVERSE_MARGIN: cfg.reverse_margin <= cfg_wdata[DIST_W-1:0];
        REG_STOP_ZONE:      cfg.stop_zone      <= cfg_wdata[DIST_W-1:0];
        REG_BASE_SPEED:     cfg.base_speed     <= cfg_wdata[BASE_W-1:0];
        REG_POWER_GAIN:     cfg.power_gain     <= cfg_wdata[GAIN_W-1:0];
        REG_STUCK_LIMIT:    cfg.stuck_limit    <= cfg_wdata[LIM_W-1:0];
        REG_RELEASE_DELAY:  cfg.release_delay  <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/rerc_core.sv */
// ----------------------------------------------------------------------------
// rerc_core
// Zone decision, dwell/middle counters and speed selection for one tick.
// State advances on each transfer out of the input register.
// ----------------------------------------------------------------------------
module rerc_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rerc_pkg::cfg_t                       cfg,
  input  logic                                 fire,
  input  logic [rerc_pkg::POSITION_WIDTH-1:0] encoder_position,
  input  logic [rerc_pkg::MSPD_W-1:0]         motor_speed,
  output rerc_pkg::result_t                    result
);
  import rerc_pkg::*;

  function automatic logic signed [SUM_W-1:0] sx_pos(input logic [POSITION_WIDTH-1:0] p);
    return $signed({{(SUM_W-POSITION_WIDTH){p[POSITION_WIDTH-1]}}, p});
  endfunction

  function automatic logic signed [SUM_W-1:0] zx_dist(input logic [DIST_W-1:0] d);
    return $signed({{(SUM_W-DIST_W){1'b0}}, d});
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // state
  logic                     reversed_seen, reversed_seen_next;
  logic [COUNT_WIDTH-1:0]   dwell_count, dwell_count_next;
  logic [COUNT_WIDTH-1:0]   middle_count, middle_count_next;
  logic [DEP_W-1:0]         departure_speed, departure_speed_next;
  logic [TSPD_W-1:0]        speed_hold, speed_hold_next;
  logic                     end_stop_hold, end_stop_hold_next;

  logic signed [SUM_W-1:0]  pos, rl, ll;
  logic                     in_right, in_left, right_far, left_far;
  logic                     spd_pos, spd_neg, rev_r, rev_l, stuck;
  logic [PROD_W-1:0]        prod;
  logic [TSPD_W-1:0]        gained, gained_neg, base_ext, base_neg, dep_ext;
  logic [DEP_W-1:0]         base_dep;

  // zone compares, exact in SUM_W bits
  assign pos       = sx_pos(encoder_position);
  assign rl        = sx_pos(cfg.right_limit);
  assign ll        = sx_pos(cfg.left_limit);
  assign in_right  = pos < (rl + zx_dist(cfg.reverse_margin));
  assign in_left   = pos > (ll - zx_dist(cfg.reverse_margin));
  assign right_far = pos > (rl + zx_dist(cfg.stop_zone));
  assign left_far  = pos < (ll - zx_dist(cfg.stop_zone));

  // measured speed direction
  assign spd_neg = motor_speed[MSPD_W-1];
  assign spd_pos = !motor_speed[MSPD_W-1] && (|motor_speed);

  // departure magnitude: Q4.8 gain, truncated
  assign prod       = cfg.base_speed * cfg.power_gain;
  assign gained     = TSPD_W'(prod[PROD_W-1:GAIN_FRAC]);
  assign gained_neg = -gained;
  assign base_ext   = TSPD_W'(cfg.base_speed);
  assign base_neg   = -base_ext;
  assign base_dep   = DEP_W'(cfg.base_speed);
  assign dep_ext    = {{(TSPD_W-DEP_W){departure_speed[DEP_W-1]}}, departure_speed};

  assign rev_r = reversed_seen || spd_pos;
  assign rev_l = reversed_seen || spd_neg;
  assign stuck = CMP_W'(sat_inc(dwell_count)) > CMP_W'(cfg.stuck_limit);

  // next state for one tick
  always_comb begin
    reversed_seen_next   = reversed_seen;
    dwell_count_next     = dwell_count;
    middle_count_next    = middle_count;
    departure_speed_next = departure_speed;
    speed_hold_next      = speed_hold;
    end_stop_hold_next   = end_stop_hold;
    if (in_right) begin
      middle_count_next    = '0;
      dwell_count_next     = sat_inc(dwell_count);
      departure_speed_next = base_dep;
      reversed_seen_next   = rev_r;
      if (!rev_r && !stuck) begin
        speed_hold_next    = base_neg;
        end_stop_hold_next = !right_far;
      end else begin
        speed_hold_next    = gained;
        end_stop_hold_next = 1'b0;
      end
    end else if (in_left) begin
      middle_count_next    = '0;
      dwell_count_next     = sat_inc(dwell_count);
      departure_speed_next = -base_dep;
      reversed_seen_next   = rev_l;
      if (!rev_l && !stuck) begin
        speed_hold_next    = base_ext;
        end_stop_hold_next = !left_far;
      end else begin
        speed_hold_next    = gained_neg;
        end_stop_hold_next = 1'b0;
      end
    end else begin
      middle_count_next  = sat_inc(middle_count);
      reversed_seen_next = 1'b0;
      dwell_count_next   = '0;
      if (CMP_W'(sat_inc(middle_count)) > CMP_W'(cfg.release_delay)) begin
        speed_hold_next    = dep_ext;
        end_stop_hold_next = 1'b0;
      end
    end
  end

  // advance state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      reversed_seen   <= 1'b0;
      dwell_count     <= '0;
      middle_count    <= '0;
      departure_speed <= '0;
      speed_hold      <= '0;
      end_stop_hold   <= 1'b0;
    end else if (fire) begin
      reversed_seen   <= reversed_seen_next;
      dwell_count     <= dwell_count_next;
      middle_count    <= middle_count_next;
      departure_speed <= departure_speed_next;
      speed_hold      <= speed_hold_next;
      end_stop_hold   <= end_stop_hold_next;
    end
  end

  assign result.target_speed = speed_hold_next;
  assign result.end_stop     = end_stop_hold_next;

endmodule

/* dv/tb_rail_end_reversal_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rail_end_reversal_controller_top
// Self-checking bench for the rail end reversal controller. A short table of
// control ticks covers the zone edges, the stop zone, reversal, forced
// departure, the release delay and the field extremes. Random phases with fresh
// register settings follow. Every result is checked against its table value or
// a cycle-free model of the controller, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_rail_end_reversal_controller_top;
  import rerc_pkg::*;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_e;
  typedef enum int {ZONE_RIGHT, ZONE_MIDDLE, ZONE_LEFT, ZONE_NOISE} zone_e;

  // one line of the directed table: a register write or a control tick
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] word;
    logic [MSPD_W-1:0]     spd;
    logic                  typed;
    logic [TSPD_W-1:0]     exp_speed;
    logic                  exp_stop;
  } step_row_t;

  localparam int DIR_ROWS     = 38;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 75;
  localparam int SETTLE_CYC   = 4;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rerc_in_if  in_ch ();
  rerc_out_if out_ch ();

  rail_end_reversal_controller_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // model copy of the registers and the tick state
  cfg_t                      rail_cfg;
  logic                      rev_seen;
  logic [COUNT_WIDTH-1:0]    dwell_cnt;
  logic [COUNT_WIDTH-1:0]    mid_cnt;
  logic signed [DEP_W-1:0]   dep_speed;
  logic signed [TSPD_W-1:0]  cmd_speed;
  logic                      cmd_stop;

  result_t pending_cmds [$];
  int      mismatches;
  bit      in_calm;
  bit      out_calm;

  step_row_t dir_table [DIR_ROWS] = '{
    // power-up settings: both limits at zero, no margin
    '{ROW_ITEM,  '0, 32'hFFFF_FFFF, 16'h0000, 1'b1, -4000,   1'b1},
    '{ROW_ITEM,  '0, 32'h8000_0000, 16'h8000, 1'b1, -4000,   1'b1},
    '{ROW_ITEM,  '0, 32'h8000_0000, 16'h0001, 1'b1, 4000,    1'b0},
    // jump straight to the left end keeps the reversal
    '{ROW_ITEM,  '0, 32'h7FFF_FFFF, 16'h7FFF, 1'b1, -4000,   1'b0},
    '{ROW_ITEM,  '0, 32'h0000_0000, 16'h0000, 1'b1, -4000,   1'b0},
    '{ROW_ITEM,  '0, 32'h7FFF_FFFF, 16'h0000, 1'b1, 4000,    1'b1},
    '{ROW_ITEM,  '0, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, -4000,   1'b0},
    '{ROW_ITEM,  '0, 32'h0000_0000, 16'h7FFF, 1'b1, -4000,   1'b0},
    // no release delay, forced departure on the first end tick
    '{ROW_WRITE, REG_RELEASE_DELAY, 32'd0, '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_STUCK_LIMIT,   32'd0, '0, 1'b0, '0, 1'b0},
    '{ROW_ITEM,  '0, -5,            16'h0000, 1'b1, 4000,    1'b0},
    // full-width base speed and gain
    '{ROW_WRITE, REG_BASE_SPEED,    32'd8191, '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_POWER_GAIN,    32'd4095, '0, 1'b0, '0, 1'b0},
    '{ROW_ITEM,  '0, -5,            16'h0000, 1'b1, 131024,  1'b0},
    '{ROW_ITEM,  '0, 10,            16'h0000, 1'b1, -131024, 1'b0},
    '{ROW_ITEM,  '0, 0,             16'h0000, 1'b1, -8191,   1'b0},
    '{ROW_WRITE, REG_POWER_GAIN,    32'd0, '0, 1'b0, '0, 1'b0},
    '{ROW_ITEM,  '0, -5,            16'h0000, 1'b1, 0,       1'b0},
    // a real rail with end zones and stop zones
    '{ROW_WRITE, REG_STUCK_LIMIT,    32'd65535, '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_RIGHT_LIMIT,    -1000,     '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_LEFT_LIMIT,     1000,      '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_REVERSE_MARGIN, 32'd100,   '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_STOP_ZONE,      32'd50,    '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_BASE_SPEED,     32'd100,   '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_POWER_GAIN,     32'd512,   '0, 1'b0, '0, 1'b0},
    '{ROW_ITEM,  '0, -900,          16'h0000, 1'b0, '0,      1'b0},
    '{ROW_ITEM,  '0, -901,          16'h0000, 1'b1, -100,    1'b0},
    '{ROW_ITEM,  '0, -950,          16'h0000, 1'b1, -100,    1'b1},
    '{ROW_ITEM,  '0, -2000,         16'h0000, 1'b1, -100,    1'b1},
    '{ROW_ITEM,  '0, -2000,         16'h0005, 1'b1, 200,     1'b0},
    '{ROW_ITEM,  '0, 900,           16'h0000, 1'b1, 100,     1'b0},
    '{ROW_ITEM,  '0, 901,           16'h0000, 1'b1, 100,     1'b0},
    '{ROW_ITEM,  '0, 950,           16'h0000, 1'b1, 100,     1'b1},
    '{ROW_ITEM,  '0, 901,           16'hFFFD, 1'b1, -200,    1'b0},
    // release after two middle ticks
    '{ROW_WRITE, REG_RELEASE_DELAY,  32'd2,     '0, 1'b0, '0, 1'b0},
    '{ROW_ITEM,  '0, 0,             16'h0000, 1'b1, -200,    1'b0},
    '{ROW_ITEM,  '0, 0,             16'h0000, 1'b1, -200,    1'b0},
    '{ROW_ITEM,  '0, 0,             16'h0000, 1'b0, '0,      1'b0}
  };

  always #5 clk = ~clk;

  function automatic logic [COUNT_WIDTH-1:0] sat_bump(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 16));
  endfunction

  // advance the controller by one tick and return its command
  function automatic result_t predict_command(input logic [POSITION_WIDTH-1:0] pos_bits,
                                              input logic [MSPD_W-1:0] spd_bits);
    longint  pos;
    longint  rlim;
    longint  llim;
    longint  margin;
    longint  stop;
    int      spd;
    int      base;
    int      gain_spd;
    result_t r;
    pos      = longint'($signed(pos_bits));
    rlim     = longint'($signed(rail_cfg.right_limit));
    llim     = longint'($signed(rail_cfg.left_limit));
    margin   = longint'(rail_cfg.reverse_margin);
    stop     = longint'(rail_cfg.stop_zone);
    spd      = int'($signed(spd_bits));
    base     = int'(rail_cfg.base_speed);
    gain_spd = (base * int'(rail_cfg.power_gain)) >>> GAIN_FRAC;
    if (pos < rlim + margin) begin
      mid_cnt   = '0;
      dwell_cnt = sat_bump(dwell_cnt);
      dep_speed = DEP_W'(base);
      if (spd > 0) rev_seen = 1'b1;
      if (!rev_seen) begin
        cmd_speed = TSPD_W'(-base);
        cmd_stop  = !(pos > rlim + stop);
      end else begin
        cmd_stop  = 1'b0;
        cmd_speed = TSPD_W'(gain_spd);
      end
      if (dwell_cnt > rail_cfg.stuck_limit) begin
        cmd_stop  = 1'b0;
        cmd_speed = TSPD_W'(gain_spd);
      end
    end else if (pos > llim - margin) begin
      dep_speed = DEP_W'(-base);
      mid_cnt   = '0;
      dwell_cnt = sat_bump(dwell_cnt);
      if (spd < 0) rev_seen = 1'b1;
      if (!rev_seen) begin
        cmd_speed = TSPD_W'(base);
        cmd_stop  = !(pos < llim - stop);
      end else begin
        cmd_stop  = 1'b0;
        cmd_speed = TSPD_W'(-gain_spd);
      end
      if (dwell_cnt > rail_cfg.stuck_limit) begin
        cmd_stop  = 1'b0;
        cmd_speed = TSPD_W'(-gain_spd);
      end
    end else begin
      mid_cnt = sat_bump(mid_cnt);
      if (mid_cnt > rail_cfg.release_delay) begin
        cmd_stop  = 1'b0;
        cmd_speed = dep_speed;
      end
      rev_seen  = 1'b0;
      dwell_cnt = '0;
    end
    r.target_speed = cmd_speed;
    r.end_stop     = cmd_stop;
    return r;
  endfunction

  // offer one tick after a random gap; record its command once transferred
  task automatic send_tick(input logic [POSITION_WIDTH-1:0] pos, input logic [MSPD_W-1:0] spd,
                           input logic typed, input result_t typed_res);
    int      gap;
    result_t res;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.encoder_position <= pos;
    in_ch.motor_speed      <= spd;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    res = predict_command(pos, spd);
    pending_cmds.push_back(typed ? typed_res : res);
  endtask

  // write one register once every command has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RIGHT_LIMIT:    rail_cfg.right_limit    = val[POSITION_WIDTH-1:0];
      REG_LEFT_LIMIT:     rail_cfg.left_limit     = val[POSITION_WIDTH-1:0];
      REG_REVERSE_MARGIN: rail_cfg.reverse_margin = val[DIST_W-1:0];
      REG_STOP_ZONE:      rail_cfg.stop_zone      = val[DIST_W-1:0];
      REG_BASE_SPEED:     rail_cfg.base_speed     = val[BASE_W-1:0];
      REG_POWER_GAIN:     rail_cfg.power_gain     = val[GAIN_W-1:0];
      REG_STUCK_LIMIT:    rail_cfg.stuck_limit    = val[LIM_W-1:0];
      REG_RELEASE_DELAY:  rail_cfg.release_delay  = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  // stimulus: directed table, then random phases
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] cfg_vals [8];
    longint                rl_v;
    longint                ll_v;
    longint                mg;
    longint                sz;
    longint                mid_v;
    longint                pos_v;
    longint                swap_v;
    int                    spd_v;
    int                    mag;
    int                    sent;
    int                    run;
    int                    pick;
    zone_e                 zone;
    result_t               typed_res;
    clk                    = 1'b0;
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_wdata              = '0;
    in_ch.valid            = 1'b0;
    in_ch.encoder_position = '0;
    in_ch.motor_speed      = '0;
    in_calm                = 1'b0;
    out_calm               = 1'b0;
    mismatches             = 0;
    rail_cfg = '{right_limit: '0, left_limit: '0, reverse_margin: '0,
                 stop_zone: RST_STOP_ZONE, base_speed: RST_BASE_SPEED,
                 power_gain: RST_POWER_GAIN, stuck_limit: RST_STUCK_LIMIT,
                 release_delay: RST_RELEASE_DELAY};
    rev_seen  = 1'b0;
    dwell_cnt = '0;
    mid_cnt   = '0;
    dep_speed = '0;
    cmd_speed = '0;
    cmd_stop  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_WRITE) begin
        write_reg(dir_table[i].reg_idx, dir_table[i].word);
      end else begin
        typed_res.target_speed = dir_table[i].exp_speed;
        typed_res.end_stop     = dir_table[i].exp_stop;
        send_tick(dir_table[i].word[POSITION_WIDTH-1:0], dir_table[i].spd,
                  dir_table[i].typed, typed_res);
      end
    end

    // random phases, each with a fresh setting of every register
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        cfg_vals[REG_RIGHT_LIMIT]    = 32'h8000_0000;
        cfg_vals[REG_LEFT_LIMIT]     = 32'h7FFF_FFFF;
        cfg_vals[REG_REVERSE_MARGIN] = 32'h00FF_FFFF;
        cfg_vals[REG_STOP_ZONE]      = 32'h00FF_FFFF;
        cfg_vals[REG_BASE_SPEED]     = 32'd8191;
        cfg_vals[REG_POWER_GAIN]     = 32'd4095;
        cfg_vals[REG_STUCK_LIMIT]    = 32'd65535;
        cfg_vals[REG_RELEASE_DELAY]  = 32'd65535;
      end else if (ph == 1) begin
        foreach (cfg_vals[r]) cfg_vals[r] = '0;
      end else begin
        rl_v = longint'($urandom_range(0, 200000)) - 100000;
        ll_v = rl_v + longint'($urandom_range(0, 200000));
        if ($urandom_range(0, 4) == 0) begin
          swap_v = rl_v;
          rl_v   = ll_v;
          ll_v   = swap_v;
        end
        if ($urandom_range(0, 5) == 0) rl_v = longint'($signed($urandom));
        cfg_vals[REG_RIGHT_LIMIT]    = rl_v[CFG_DATA_W-1:0];
        cfg_vals[REG_LEFT_LIMIT]     = ll_v[CFG_DATA_W-1:0];
        cfg_vals[REG_REVERSE_MARGIN] = ($urandom_range(0, 7) == 0) ? $urandom & 32'hFF_FFFF
                                                                   : $urandom_range(0, 3000);
        cfg_vals[REG_STOP_ZONE]      = ($urandom_range(0, 7) == 0) ? $urandom & 32'hFF_FFFF
                                                                   : $urandom_range(0, 4000);
        cfg_vals[REG_BASE_SPEED]     = $urandom_range(0, 8191);
        cfg_vals[REG_POWER_GAIN]     = $urandom_range(0, 4095);
        case ($urandom_range(0, 7))
          0:       cfg_vals[REG_STUCK_LIMIT] = 32'd65535;
          1:       cfg_vals[REG_STUCK_LIMIT] = $urandom & 32'hFFFF;
          default: cfg_vals[REG_STUCK_LIMIT] = $urandom_range(0, 40);
        endcase
        case ($urandom_range(0, 7))
          0:       cfg_vals[REG_RELEASE_DELAY] = 32'd65535;
          1:       cfg_vals[REG_RELEASE_DELAY] = $urandom & 32'hFFFF;
          default: cfg_vals[REG_RELEASE_DELAY] = $urandom_range(0, 30);
        endcase
      end
      for (int r = 0; r < 8; r++) write_reg(CFG_IDX_W'(r), cfg_vals[r]);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);

      // runs of ticks that stay in one zone, with some noise between them
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        zone = (pick < 2) ? ZONE_NOISE : (pick < 5) ? ZONE_RIGHT :
               (pick < 8) ? ZONE_LEFT : ZONE_MIDDLE;
        run  = (zone == ZONE_NOISE) ? $urandom_range(1, 4) : $urandom_range(1, 50);
        if (run > PHASE_ITEMS - sent) run = PHASE_ITEMS - sent;
        rl_v  = longint'($signed(rail_cfg.right_limit));
        ll_v  = longint'($signed(rail_cfg.left_limit));
        mg    = longint'(rail_cfg.reverse_margin);
        sz    = longint'(rail_cfg.stop_zone);
        mid_v = (rl_v + ll_v) / 2;
        for (int k = 0; k < run; k++) begin
          pick = $urandom_range(0, 3);
          mag  = $urandom_range(0, 32768);
          case (zone)
            ZONE_RIGHT: begin
              case (pick)
                0:       pos_v = rl_v + mg - 1 - longint'($urandom_range(0, 2));
                1:       pos_v = rl_v + sz + longint'($urandom_range(0, 4)) - 2;
                2:       pos_v = rl_v - longint'($urandom_range(0, 5000));
                default: pos_v = rl_v + mg - 1 - longint'($urandom_range(0, int'(mg)));
              endcase
              // mostly heading into the end, now and then reversed
              spd_v = ($urandom_range(0, 5) == 0) ? mag : -mag;
            end
            ZONE_LEFT: begin
              case (pick)
                0:       pos_v = ll_v - mg + 1 + longint'($urandom_range(0, 2));
                1:       pos_v = ll_v - sz + longint'($urandom_range(0, 4)) - 2;
                2:       pos_v = ll_v + longint'($urandom_range(0, 5000));
                default: pos_v = ll_v - mg + 1 + longint'($urandom_range(0, int'(mg)));
              endcase
              spd_v = ($urandom_range(0, 5) == 0) ? -mag : mag;
            end
            ZONE_MIDDLE: begin
              case (pick)
                0:       pos_v = rl_v + mg;
                1:       pos_v = ll_v - mg;
                default: pos_v = mid_v + longint'($urandom_range(0, 20)) - 10;
              endcase
              spd_v = int'($urandom);
            end
            default: begin
              pos_v = longint'($urandom);
              spd_v = int'($urandom);
            end
          endcase
          send_tick(pos_v[POSITION_WIDTH-1:0], spd_v[MSPD_W-1:0], 1'b0, '0);
        end
        sent += run;
      end
    end

    // drain and report
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("rail_end_reversal_controller_top: match");
    end else begin
      $display("rail_end_reversal_controller_top: mismatch");
    end
    $finish;
  end

  // result side: random stalls, compare each transfer with the oldest command
  initial begin : result_sink
    int      stall;
    result_t got;
    result_t want;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.target_speed = out_ch.target_speed;
      got.end_stop     = out_ch.end_stop;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got speed %0d stop %0b",
                 $time, $signed(got.target_speed), got.end_stop);
      end else begin
        want = pending_cmds.pop_front();
        if (got.target_speed !== want.target_speed) begin
          mismatches++;
          $display("%0t: target_speed expected %0d, got %0d", $time,
                   $signed(want.target_speed), $signed(got.target_speed));
        end
        if (got.end_stop !== want.end_stop) begin
          mismatches++;
          $display("%0t: end_stop expected %0b, got %0b", $time,
                   want.end_stop, got.end_stop);
        end
      end
    end
  end

  // stop a hung run
  initial begin : watchdog
    #10_000_000;
    $display("rail_end_reversal_controller_top: mismatch");
    $finish;
  end

endmodule

/* sim.f */
src/rerc_pkg.sv
src/rerc_if.sv
src/rerc_cfg_regs.sv
src/rerc_core.sv
src/rail_end_reversal_controller_top.sv
dv/tb_rail_end_reversal_controller_top.sv
